@@ design/pws_pkg.sv @@
// Shared constants, register codes and helpers of the world-to-screen projection.
package pws_pkg;

	localparam int COORD_BITS = 32;
	localparam int COEF_BITS = 32;
	localparam int PROD_BITS = COEF_BITS + COORD_BITS;
	localparam int TERM_BITS = PROD_BITS - 16;
	localparam int CLIP_BITS = TERM_BITS + 2;
	localparam int DEN_BITS = CLIP_BITS - 1;
	localparam int QUO_BITS = 35;
	localparam int DIV_STEPS = QUO_BITS;
	localparam int DIV_LAT = DIV_STEPS + 2;
	localparam int NDC_BITS = 35;
	localparam int HI_BITS = CLIP_BITS - (QUO_BITS - 16);
	localparam int SIZE_BITS = 14;
	localparam int BCLIP_BITS = 26;
	localparam int BPROD_BITS = BCLIP_BITS + 18;
	localparam int WIDE_BITS = 52;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic signed [CLIP_BITS-1:0] W_MIN_Q24 = 50'sd16778;
	localparam logic [QUO_BITS-1:0] NDC_LIMIT = 35'h2_0000_0000;
	localparam logic signed [CLIP_BITS-1:0] BCLIP_LIMIT = 50'sd16777216;
	localparam logic signed [17:0] BEHIND_SCALE = 18'sd100000;
	localparam logic [SIZE_BITS-1:0] WIDTH_RESET = 14'd1920;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 14'd1080;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW0_A,
		REG_ROW0_B,
		REG_ROW1_A,
		REG_ROW1_B,
		REG_ROW3_A,
		REG_ROW3_B,
		REG_WIDTH,
		REG_HEIGHT
	} cfg_reg_t;

	// Clamp a wide signed value to the signed coordinate range
	function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [WIDE_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] hi;
		logic signed [WIDE_BITS-1:0] lo;
		hi = 52'sd2147483647;
		lo = -52'sd2147483648;
		if (v > hi) begin
			return 32'h7FFF_FFFF;
		end else if (v < lo) begin
			return 32'h8000_0000;
		end
		return v[COORD_BITS-1:0];
	endfunction

endpackage

@@ design/pws_div.sv @@
// Pipelined restoring divider: floor(num * 2^16 / den), clamped to +-2^33.
module pws_div
	import pws_pkg::*;
(
	input  logic                        clk,
	input  logic signed [CLIP_BITS-1:0] num,
	input  logic [DEN_BITS-1:0]         den,
	output logic signed [NDC_BITS-1:0]  ndc
);

	logic [DEN_BITS-1:0] rem_sd [0:DIV_STEPS];
	logic [DEN_BITS-1:0] den_sd [0:DIV_STEPS];
	logic [QUO_BITS-1:0] quo_sd [0:DIV_STEPS];
	logic [QUO_BITS-1:0] nb_sd  [0:DIV_STEPS];
	logic                neg_sd [0:DIV_STEPS];
	logic                ovf_sd [0:DIV_STEPS];

	logic                 neg_in;
	logic [CLIP_BITS-1:0] mag_in;
	logic [HI_BITS-1:0]   hi_in;
	logic                 ovf_in;

	// Take the magnitude and check the quotient fits
	always_comb begin
		neg_in = num[CLIP_BITS-1];
		mag_in = neg_in ? CLIP_BITS'(-num) : CLIP_BITS'(num);
		hi_in  = mag_in[CLIP_BITS-1 -: HI_BITS];
		ovf_in = DEN_BITS'(hi_in) >= den;
	end

	// Load the first stage
	always_ff @(posedge clk) begin
		rem_sd[0] <= ovf_in ? '0 : DEN_BITS'(hi_in);
		den_sd[0] <= den;
		quo_sd[0] <= '0;
		nb_sd[0]  <= {mag_in[QUO_BITS-17:0], 16'b0};
		neg_sd[0] <= neg_in;
		ovf_sd[0] <= ovf_in;
	end

	// One quotient bit per stage
	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			logic [DEN_BITS:0] cand;
			logic              ge;
			cand = {rem_sd[k], nb_sd[k][QUO_BITS-1]};
			ge   = cand >= {1'b0, den_sd[k]};
			rem_sd[k+1] <= ge ? DEN_BITS'(cand - {1'b0, den_sd[k]}) : cand[DEN_BITS-1:0];
			quo_sd[k+1] <= {quo_sd[k][QUO_BITS-2:0], ge};
			nb_sd[k+1]  <= nb_sd[k] << 1;
			den_sd[k+1] <= den_sd[k];
			neg_sd[k+1] <= neg_sd[k];
			ovf_sd[k+1] <= ovf_sd[k];
		end
	end

	logic [QUO_BITS:0]          up_mag;
	logic signed [NDC_BITS-1:0] ndc_next;

	// Apply the sign with floor rounding and clamp
	always_comb begin
		up_mag = {1'b0, quo_sd[DIV_STEPS]} + (QUO_BITS+1)'(|rem_sd[DIV_STEPS]);
		if (!neg_sd[DIV_STEPS]) begin
			if (ovf_sd[DIV_STEPS] || quo_sd[DIV_STEPS] > NDC_LIMIT) begin
				ndc_next = $signed(NDC_LIMIT);
			end else begin
				ndc_next = $signed(quo_sd[DIV_STEPS]);
			end
		end else begin
			if (ovf_sd[DIV_STEPS] || up_mag > {1'b0, NDC_LIMIT}) begin
				ndc_next = -$signed(NDC_LIMIT);
			end else begin
				ndc_next = -$signed(up_mag[NDC_BITS-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		ndc <= ndc_next;
	end

endmodule

@@ design/perspective_world_to_screen_top.sv @@
// Top level of the perspective world-to-screen projection pipeline.
//
//  channel   signals                                   handshake
//  input     world_x, world_y, world_z                 start, busy (transfer: start & !busy)
//  result    visible, screen_x, screen_y               done strobe, one cycle
//  config    cfg_index, cfg_data                       cfg_we, no wait
//
// One point enters every cycle; busy stays low.
// Each result passes two stages for the dot products,
// 37 for the divider (one quotient bit per step stage), two for scaling.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so nothing is held back.
module perspective_world_to_screen_top
	import pws_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COORD_BITS-1:0]     world_x,
	input  logic signed [COORD_BITS-1:0]     world_y,
	input  logic signed [COORD_BITS-1:0]     world_z,
	input  logic                             cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]         cfg_data,
	output logic                             done,
	output logic                             visible,
	output logic signed [COORD_BITS-1:0]     screen_x,
	output logic signed [COORD_BITS-1:0]     screen_y
);

	localparam int PIPE_LAT = DIV_LAT + 4;

	logic [CFG_DATA_BITS-1:0] row0_a_q, row0_b_q, row1_a_q, row1_b_q, row3_a_q, row3_b_q;
	logic [SIZE_BITS-1:0]     width_q, height_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_a_q <= '0;
			row0_b_q <= '0;
			row1_a_q <= '0;
			row1_b_q <= '0;
			row3_a_q <= '0;
			row3_b_q <= '0;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW0_A: row0_a_q <= cfg_data;
				REG_ROW0_B: row0_b_q <= cfg_data;
				REG_ROW1_A: row1_a_q <= cfg_data;
				REG_ROW1_B: row1_b_q <= cfg_data;
				REG_ROW3_A: row3_a_q <= cfg_data;
				REG_ROW3_B: row3_b_q <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[SIZE_BITS-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: the nine coefficient products
	logic                        valid_s1;
	logic signed [PROD_BITS-1:0] px0_s1, py0_s1, pz0_s1;
	logic signed [PROD_BITS-1:0] px1_s1, py1_s1, pz1_s1;
	logic signed [PROD_BITS-1:0] px3_s1, py3_s1, pz3_s1;
	logic signed [COEF_BITS-1:0] t0_s1, t1_s1, t3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		px0_s1 <= $signed(row0_a_q[31:0])  * world_x;
		py0_s1 <= $signed(row0_a_q[63:32]) * world_y;
		pz0_s1 <= $signed(row0_b_q[31:0])  * world_z;
		px1_s1 <= $signed(row1_a_q[31:0])  * world_x;
		py1_s1 <= $signed(row1_a_q[63:32]) * world_y;
		pz1_s1 <= $signed(row1_b_q[31:0])  * world_z;
		px3_s1 <= $signed(row3_a_q[31:0])  * world_x;
		py3_s1 <= $signed(row3_a_q[63:32]) * world_y;
		pz3_s1 <= $signed(row3_b_q[31:0])  * world_z;
		t0_s1  <= $signed(row0_b_q[63:32]);
		t1_s1  <= $signed(row1_b_q[63:32]);
		t3_s1  <= $signed(row3_b_q[63:32]);
	end

	// Stage 2: floor each product to Q.24 and sum the row
	logic                        valid_s2;
	logic signed [CLIP_BITS-1:0] cx_s2, cy_s2, w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cx_s2 <= CLIP_BITS'(px0_s1 >>> 16) + CLIP_BITS'(py0_s1 >>> 16)
			+ CLIP_BITS'(pz0_s1 >>> 16) + CLIP_BITS'(t0_s1);
		cy_s2 <= CLIP_BITS'(px1_s1 >>> 16) + CLIP_BITS'(py1_s1 >>> 16)
			+ CLIP_BITS'(pz1_s1 >>> 16) + CLIP_BITS'(t1_s1);
		w_s2  <= CLIP_BITS'(px3_s1 >>> 16) + CLIP_BITS'(py3_s1 >>> 16)
			+ CLIP_BITS'(pz3_s1 >>> 16) + CLIP_BITS'(t3_s1);
	end

	// Divide clip x and y by w
	logic signed [NDC_BITS-1:0] ndc_x, ndc_y;

	pws_div u_div_x (
		.clk (clk),
		.num (cx_s2),
		.den (w_s2[DEN_BITS-1:0]),
		.ndc (ndc_x)
	);

	pws_div u_div_y (
		.clk (clk),
		.num (cy_s2),
		.den (w_s2[DEN_BITS-1:0]),
		.ndc (ndc_y)
	);

	// Behind-viewer clip values clamped where the output saturates anyway
	logic signed [BCLIP_BITS-1:0] bcx_in, bcy_in;

	always_comb begin
		if (cx_s2 > BCLIP_LIMIT) begin
			bcx_in = BCLIP_BITS'(BCLIP_LIMIT);
		end else if (cx_s2 < -BCLIP_LIMIT) begin
			bcx_in = BCLIP_BITS'(-BCLIP_LIMIT);
		end else begin
			bcx_in = BCLIP_BITS'(cx_s2);
		end
		if (cy_s2 > BCLIP_LIMIT) begin
			bcy_in = BCLIP_BITS'(BCLIP_LIMIT);
		end else if (cy_s2 < -BCLIP_LIMIT) begin
			bcy_in = BCLIP_BITS'(-BCLIP_LIMIT);
		end else begin
			bcy_in = BCLIP_BITS'(cy_s2);
		end
	end

	// Side pipeline alongside the divider
	logic                         vld_sd [0:DIV_LAT-1];
	logic                         vis_sd [0:DIV_LAT-1];
	logic signed [BCLIP_BITS-1:0] bcx_sd [0:DIV_LAT-1];
	logic signed [BCLIP_BITS-1:0] bcy_sd [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else begin
			vld_sd[0] <= valid_s2;
			for (int k = 1; k < DIV_LAT; k++) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		vis_sd[0] <= w_s2 >= W_MIN_Q24;
		bcx_sd[0] <= bcx_in;
		bcy_sd[0] <= bcy_in;
		for (int k = 1; k < DIV_LAT; k++) begin
			vis_sd[k] <= vis_sd[k-1];
			bcx_sd[k] <= bcx_sd[k-1];
			bcy_sd[k] <= bcy_sd[k-1];
		end
	end

	// Multiply stage: pixel scale and behind-viewer scale
	logic                          valid_sm, vis_sm;
	logic signed [CLIP_BITS-1:0]   px_sm, py_sm;
	logic signed [BPROD_BITS-1:0]  bx_sm, by_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sm <= 1'b0;
		end else begin
			valid_sm <= vld_sd[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		vis_sm <= vis_sd[DIV_LAT-1];
		px_sm  <= ndc_x * $signed({1'b0, width_q});
		py_sm  <= ndc_y * $signed({1'b0, height_q});
		bx_sm  <= bcx_sd[DIV_LAT-1] * BEHIND_SCALE;
		by_sm  <= bcy_sd[DIV_LAT-1] * BEHIND_SCALE;
	end

	// Offset to the viewport center, select and saturate
	logic signed [WIDE_BITS-1:0] sx_wide, sy_wide, bx_wide, by_wide;

	always_comb begin
		sx_wide = $signed(WIDE_BITS'({width_q, 15'b0})) + WIDE_BITS'(px_sm >>> 1);
		sy_wide = $signed(WIDE_BITS'({height_q, 15'b0})) - WIDE_BITS'(py_sm >>> 1);
		bx_wide = WIDE_BITS'(bx_sm >>> 8);
		by_wide = WIDE_BITS'(by_sm >>> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_sm;
		end
	end

	always_ff @(posedge clk) begin
		visible  <= vis_sm;
		screen_x <= vis_sm ? sat_coord(sx_wide) : sat_coord(bx_wide);
		screen_y <= vis_sm ? sat_coord(sy_wide) : sat_coord(by_wide);
	end

	// Every result matches an earlier transfer
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LAT))
		else $error("result without matching transfer");

	a_accept_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LAT done)
		else $error("transfer lost in pipeline");

	a_visible_from_w: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (visible == $past(w_s2 >= W_MIN_Q24, PIPE_LAT - 2)))
		else $error("visible flag out of step with w");

endmodule
